// ===== sv/im2col_pkg.sv =====
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared widths, register indexes and types of the im2col address generator.
// ----------------------------------------------------------------------------
package im2col_pkg;

  localparam int DEF_INDEX_BITS = 24;
  localparam int DEF_DIM_BITS   = 10;

  localparam int BATCH_BITS     = 8;
  localparam int CHAN_BITS      = 12;
  localparam int KSZ_BITS       = 4;
  localparam int SHAPE_BITS     = 8;
  localparam int KK_BITS        = 2 * KSZ_BITS;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [SHAPE_BITS-1:0] RST_SHAPE = 8'h11;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BATCH_COUNT  = 3'd0,
    REG_IN_HEIGHT    = 3'd1,
    REG_IN_WIDTH     = 3'd2,
    REG_OUT_HEIGHT   = 3'd3,
    REG_OUT_WIDTH    = 3'd4,
    REG_CHANNELS     = 3'd5,
    REG_KERNEL_SHAPE = 3'd6,
    REG_STRIDE_SHAPE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic active;
    logic patch_end;
    logic last;
  } walk_flags_t;

endpackage

// ===== sv/im2col_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// im2col_cfg_regs
// Configuration registers; gives the loop limits with zero taken as one.
// ----------------------------------------------------------------------------
module im2col_cfg_regs #(
  parameter int DIM_BITS      = im2col_pkg::DEF_DIM_BITS,
  parameter int CFG_DATA_BITS = im2col_pkg::CHAN_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [im2col_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]             cfg_data,
  output logic [im2col_pkg::BATCH_BITS-1:0]    nb,
  output logic [DIM_BITS-1:0]                  hh,
  output logic [DIM_BITS-1:0]                  ww,
  output logic [DIM_BITS-1:0]                  oh,
  output logic [DIM_BITS-1:0]                  ow,
  output logic [im2col_pkg::CHAN_BITS-1:0]     cc,
  output logic [im2col_pkg::KSZ_BITS-1:0]      kh,
  output logic [im2col_pkg::KSZ_BITS-1:0]      kw,
  output logic [im2col_pkg::KSZ_BITS-1:0]      sh,
  output logic [im2col_pkg::KSZ_BITS-1:0]      sw
);
  import im2col_pkg::*;

  logic [BATCH_BITS-1:0] batch_count;
  logic [DIM_BITS-1:0]   in_height;
  logic [DIM_BITS-1:0]   in_width;
  logic [DIM_BITS-1:0]   out_height;
  logic [DIM_BITS-1:0]   out_width;
  logic [CHAN_BITS-1:0]  channels;
  logic [SHAPE_BITS-1:0] kernel_shape;
  logic [SHAPE_BITS-1:0] stride_shape;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count  <= BATCH_BITS'(1);
      in_height    <= DIM_BITS'(1);
      in_width     <= DIM_BITS'(1);
      out_height   <= DIM_BITS'(1);
      out_width    <= DIM_BITS'(1);
      channels     <= CHAN_BITS'(1);
      kernel_shape <= RST_SHAPE;
      stride_shape <= RST_SHAPE;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BATCH_COUNT:  batch_count  <= cfg_data[BATCH_BITS-1:0];
        REG_IN_HEIGHT:    in_height    <= cfg_data[DIM_BITS-1:0];
        REG_IN_WIDTH:     in_width     <= cfg_data[DIM_BITS-1:0];
        REG_OUT_HEIGHT:   out_height   <= cfg_data[DIM_BITS-1:0];
        REG_OUT_WIDTH:    out_width    <= cfg_data[DIM_BITS-1:0];
        REG_CHANNELS:     channels     <= cfg_data[CHAN_BITS-1:0];
        REG_KERNEL_SHAPE: kernel_shape <= cfg_data[SHAPE_BITS-1:0];
        REG_STRIDE_SHAPE: stride_shape <= cfg_data[SHAPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a zero size behaves as one
  assign nb = (batch_count == '0) ? BATCH_BITS'(1) : batch_count;
  assign hh = (in_height == '0) ? DIM_BITS'(1) : in_height;
  assign ww = (in_width == '0) ? DIM_BITS'(1) : in_width;
  assign oh = (out_height == '0) ? DIM_BITS'(1) : out_height;
  assign ow = (out_width == '0) ? DIM_BITS'(1) : out_width;
  assign cc = (channels == '0) ? CHAN_BITS'(1) : channels;
  assign kh = (kernel_shape[KSZ_BITS-1:0] == '0) ? KSZ_BITS'(1)
            : kernel_shape[KSZ_BITS-1:0];
  assign kw = (kernel_shape[SHAPE_BITS-1:KSZ_BITS] == '0) ? KSZ_BITS'(1)
            : kernel_shape[SHAPE_BITS-1:KSZ_BITS];
  assign sh = (stride_shape[KSZ_BITS-1:0] == '0) ? KSZ_BITS'(1)
            : stride_shape[KSZ_BITS-1:0];
  assign sw = (stride_shape[SHAPE_BITS-1:KSZ_BITS] == '0) ? KSZ_BITS'(1)
            : stride_shape[SHAPE_BITS-1:KSZ_BITS];

endmodule

// ===== sv/im2col_walk.sv =====
// ----------------------------------------------------------------------------
// im2col_walk
// Nested loop counters of the unfold; latches the position of each item.
// ----------------------------------------------------------------------------
module im2col_walk #(
  parameter int DIM_BITS = im2col_pkg::DEF_DIM_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step_valid,
  output logic                              step_ready,
  input  logic                              restart,
  input  logic [im2col_pkg::BATCH_BITS-1:0] nb,
  input  logic [DIM_BITS-1:0]               oh,
  input  logic [DIM_BITS-1:0]               ow,
  input  logic [im2col_pkg::CHAN_BITS-1:0]  cc,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   kh,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   kw,
  output logic                              item_valid,
  input  logic                              item_ready,
  output im2col_pkg::walk_flags_t           item_flags,
  output logic [im2col_pkg::BATCH_BITS-1:0] item_batch,
  output logic [DIM_BITS-1:0]               item_orow,
  output logic [DIM_BITS-1:0]               item_ocol,
  output logic [im2col_pkg::CHAN_BITS-1:0]  item_chan,
  output logic [im2col_pkg::KSZ_BITS-1:0]   item_krow,
  output logic [im2col_pkg::KSZ_BITS-1:0]   item_kcol
);
  import im2col_pkg::*;

  logic [BATCH_BITS-1:0] batch_pos, batch_cur, batch_next;
  logic [DIM_BITS-1:0]   orow_pos, orow_cur, orow_next;
  logic [DIM_BITS-1:0]   ocol_pos, ocol_cur, ocol_next;
  logic [CHAN_BITS-1:0]  chan_pos, chan_cur, chan_next;
  logic [KSZ_BITS-1:0]   krow_pos, krow_cur, krow_next;
  logic [KSZ_BITS-1:0]   kcol_pos, kcol_cur, kcol_next;
  logic                  pass_active, pass_active_next;
  logic                  act, accept;
  logic                  wrap_batch, wrap_orow, wrap_ocol, wrap_chan, wrap_krow, wrap_kcol;
  logic                  cy_batch, cy_orow, cy_ocol, cy_chan, cy_krow;
  logic                  pend, fin;

  assign step_ready = ~item_valid | item_ready;
  assign accept     = step_valid & step_ready;

  always_comb begin
    batch_cur = restart ? '0 : batch_pos;
    orow_cur  = restart ? '0 : orow_pos;
    ocol_cur  = restart ? '0 : ocol_pos;
    chan_cur  = restart ? '0 : chan_pos;
    krow_cur  = restart ? '0 : krow_pos;
    kcol_cur  = restart ? '0 : kcol_pos;
    act       = restart | pass_active;

    // a position at or past the last value below its limit ends its loop
    wrap_kcol  = (KSZ_BITS+1)'(kcol_cur) + (KSZ_BITS+1)'(1) >= (KSZ_BITS+1)'(kw);
    wrap_krow  = (KSZ_BITS+1)'(krow_cur) + (KSZ_BITS+1)'(1) >= (KSZ_BITS+1)'(kh);
    wrap_chan  = (CHAN_BITS+1)'(chan_cur) + (CHAN_BITS+1)'(1) >= (CHAN_BITS+1)'(cc);
    wrap_ocol  = (DIM_BITS+1)'(ocol_cur) + (DIM_BITS+1)'(1) >= (DIM_BITS+1)'(ow);
    wrap_orow  = (DIM_BITS+1)'(orow_cur) + (DIM_BITS+1)'(1) >= (DIM_BITS+1)'(oh);
    wrap_batch = (BATCH_BITS+1)'(batch_cur) + (BATCH_BITS+1)'(1)
                 >= (BATCH_BITS+1)'(nb);

    cy_krow  = wrap_kcol;
    cy_chan  = cy_krow & wrap_krow;
    cy_ocol  = cy_chan & wrap_chan;
    cy_orow  = cy_ocol & wrap_ocol;
    cy_batch = cy_orow & wrap_orow;
    pend     = cy_ocol;
    fin      = cy_batch & wrap_batch;

    // on the final pair every loop wraps, so all positions return to zero
    kcol_next  = wrap_kcol ? '0 : kcol_cur + KSZ_BITS'(1);
    krow_next  = ~cy_krow ? krow_cur : (wrap_krow ? '0 : krow_cur + KSZ_BITS'(1));
    chan_next  = ~cy_chan ? chan_cur : (wrap_chan ? '0 : chan_cur + CHAN_BITS'(1));
    ocol_next  = ~cy_ocol ? ocol_cur : (wrap_ocol ? '0 : ocol_cur + DIM_BITS'(1));
    orow_next  = ~cy_orow ? orow_cur : (wrap_orow ? '0 : orow_cur + DIM_BITS'(1));
    batch_next = ~cy_batch ? batch_cur
               : (wrap_batch ? '0 : batch_cur + BATCH_BITS'(1));
    pass_active_next = act & ~fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_pos   <= '0;
      orow_pos    <= '0;
      ocol_pos    <= '0;
      chan_pos    <= '0;
      krow_pos    <= '0;
      kcol_pos    <= '0;
      pass_active <= 1'b0;
      item_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (act) begin
          batch_pos <= batch_next;
          orow_pos  <= orow_next;
          ocol_pos  <= ocol_next;
          chan_pos  <= chan_next;
          krow_pos  <= krow_next;
          kcol_pos  <= kcol_next;
        end
        pass_active <= pass_active_next;
      end
      if (step_ready) begin
        item_valid <= step_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_flags.active    <= act;
      item_flags.patch_end <= pend;
      item_flags.last      <= fin;
      item_batch           <= batch_cur;
      item_orow            <= orow_cur;
      item_ocol            <= ocol_cur;
      item_chan            <= chan_cur;
      item_krow            <= krow_cur;
      item_kcol            <= kcol_cur;
    end
  end

`ifndef SYNTH
  a_fin_ends_pass: assert property (@(posedge clk) disable iff (rst)
    accept && act && fin |=> !pass_active)
    else $error("pass still running after its final pair");

  a_restart_starts: assert property (@(posedge clk) disable iff (rst)
    accept && restart && !fin |=> pass_active)
    else $error("restart did not start a pass");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !act |=> !pass_active && $stable(kcol_pos) && $stable(batch_pos))
    else $error("loop counters moved with no pass running");
`endif

endmodule

// ===== sv/im2col_index_pipe.sv =====
// ----------------------------------------------------------------------------
// im2col_index_pipe
// Three-stage multiply-add pipeline forming tensor and column indices.
// ----------------------------------------------------------------------------
module im2col_index_pipe #(
  parameter int INDEX_BITS = im2col_pkg::DEF_INDEX_BITS,
  parameter int DIM_BITS   = im2col_pkg::DEF_DIM_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  im2col_pkg::walk_flags_t           item_flags,
  input  logic [im2col_pkg::BATCH_BITS-1:0] item_batch,
  input  logic [DIM_BITS-1:0]               item_orow,
  input  logic [DIM_BITS-1:0]               item_ocol,
  input  logic [im2col_pkg::CHAN_BITS-1:0]  item_chan,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   item_krow,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   item_kcol,
  input  logic [DIM_BITS-1:0]               hh,
  input  logic [DIM_BITS-1:0]               ww,
  input  logic [DIM_BITS-1:0]               oh,
  input  logic [DIM_BITS-1:0]               ow,
  input  logic [im2col_pkg::CHAN_BITS-1:0]  cc,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   kh,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   kw,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   sh,
  input  logic [im2col_pkg::KSZ_BITS-1:0]   sw,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              valid_res,
  output logic [INDEX_BITS-1:0]             tensor_index,
  output logic [INDEX_BITS-1:0]             column_index,
  output logic                              patch_end,
  output logic                              last,
  output logic                              index_overflow
);
  import im2col_pkg::*;

  localparam int A_W    = BATCH_BITS + CHAN_BITS + 1;
  localparam int IH_W   = KSZ_BITS + DIM_BITS + 1;
  localparam int R1_W   = BATCH_BITS + DIM_BITS + 1;
  localparam int Q1_W   = CHAN_BITS + KSZ_BITS + 1;
  localparam int Q2_W   = Q1_W + KSZ_BITS + 1;
  localparam int CCW_W  = CHAN_BITS + KK_BITS;
  localparam int BX_W   = A_W + DIM_BITS + 1;
  localparam int B_W    = (BX_W > INDEX_BITS) ? BX_W : INDEX_BITS + 1;
  localparam int RX_W   = R1_W + DIM_BITS + 1;
  localparam int R2_W   = (RX_W > INDEX_BITS) ? RX_W : INDEX_BITS + 1;
  localparam int T_W    = INDEX_BITS + DIM_BITS + 1;
  localparam int C_W    = INDEX_BITS + CCW_W + 1;

  logic rdy_out, rdy_2, rdy_1;

  // stage 1: first products of each factorised index
  logic              v1;
  walk_flags_t       f1;
  logic [A_W-1:0]    a1;
  logic [IH_W-1:0]   ih1, iw1;
  logic [R1_W-1:0]   r1;
  logic [Q1_W-1:0]   q1;
  logic [KK_BITS-1:0] kk1;
  logic [KSZ_BITS-1:0] kcol1;
  logic [DIM_BITS-1:0] ocol1;

  // stage 2: partial indices, folded to the index width with an overflow mark
  logic              v2;
  walk_flags_t       f2;
  logic [INDEX_BITS-1:0] b2, r2;
  logic              b_ovf2, r_ovf2;
  logic [IH_W-1:0]   iw2;
  logic [Q2_W-1:0]   q2;
  logic [CCW_W-1:0]  ccw2;

  logic [B_W-1:0]    b_full;
  logic [R2_W-1:0]   r_full;
  logic [T_W-1:0]    t_full;
  logic [C_W-1:0]    c_full;

  assign rdy_out    = ~result_valid | result_ready;
  assign rdy_2      = ~v2 | rdy_out;
  assign rdy_1      = ~v1 | rdy_2;
  assign item_ready = rdy_1;

  // low bits of a product depend only on low bits of its factors, and a
  // partial index that already overflows makes the final one overflow too
  assign b_full = B_W'(a1) * B_W'(hh) + B_W'(ih1);
  assign r_full = R2_W'(r1) * R2_W'(ow) + R2_W'(ocol1);
  assign t_full = T_W'(b2) * T_W'(ww) + T_W'(iw2);
  assign c_full = C_W'(r2) * C_W'(ccw2) + C_W'(q2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy_1) begin
        v1 <= item_valid;
      end
      if (rdy_2) begin
        v2 <= v1;
      end
      if (rdy_out) begin
        result_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_1) begin
      f1    <= item_flags;
      a1    <= A_W'(item_batch) * A_W'(cc) + A_W'(item_chan);
      ih1   <= IH_W'(sh) * IH_W'(item_orow) + IH_W'(item_krow);
      iw1   <= IH_W'(sw) * IH_W'(item_ocol) + IH_W'(item_kcol);
      r1    <= R1_W'(item_batch) * R1_W'(oh) + R1_W'(item_orow);
      q1    <= Q1_W'(item_chan) * Q1_W'(kh) + Q1_W'(item_krow);
      kk1   <= KK_BITS'(kh) * KK_BITS'(kw);
      kcol1 <= item_kcol;
      ocol1 <= item_ocol;
    end
    if (rdy_2) begin
      f2     <= f1;
      b2     <= b_full[INDEX_BITS-1:0];
      b_ovf2 <= |b_full[B_W-1:INDEX_BITS];
      r2     <= r_full[INDEX_BITS-1:0];
      r_ovf2 <= |r_full[R2_W-1:INDEX_BITS];
      iw2    <= iw1;
      q2     <= Q2_W'(q1) * Q2_W'(kw) + Q2_W'(kcol1);
      ccw2   <= CCW_W'(cc) * CCW_W'(kk1);
    end
    if (rdy_out) begin
      // no pass running: an all-zero result
      valid_res      <= f2.active;
      tensor_index   <= f2.active ? t_full[INDEX_BITS-1:0] : '0;
      column_index   <= f2.active ? c_full[INDEX_BITS-1:0] : '0;
      patch_end      <= f2.active & f2.patch_end;
      last           <= f2.active & f2.last;
      index_overflow <= f2.active & (b_ovf2 | r_ovf2 | (|t_full[T_W-1:INDEX_BITS])
                        | (|c_full[C_W-1:INDEX_BITS]));
    end
  end

`ifndef SYNTH
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !valid_res |-> tensor_index == '0 && column_index == '0
      && !patch_end && !last && !index_overflow)
    else $error("result outside a pass carries data");

  a_last_ends_patch: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> patch_end)
    else $error("final pair not at the end of a patch");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !rdy_out |=> v2 && $stable(t_full) && $stable(c_full))
    else $error("stalled stage lost its item");
`endif

endmodule

// ===== sv/im2col_address_generator.sv =====
// ----------------------------------------------------------------------------
// im2col_address_generator
// Index pair generator for convolution unfold (im2col) and fold (col2im).
// ----------------------------------------------------------------------------
// Usage: write the shape registers through cfg_we/cfg_index/cfg_data while
// the block is idle. Each item on the step channel (restart high to begin a
// pass, low to advance) yields one item on the result channel: a tensor index
// and a column-matrix index, with patch_end on the last element of a matrix
// row, last on the final pair and index_overflow when an index wrapped.
// Steps outside a pass give an item with valid_res low and all fields zero.
// Throughput: one item per cycle on both channels while the receiver does not
// stall. The result of an accepted item passes through the counter register
// and three multiply-add stages.
// A stalled receiver holds the result register; the stages behind it keep
// filling and step_ready drops only once all four stages hold items.
// Reset restores the register defaults (all sizes one) and ends any pass.
// ----------------------------------------------------------------------------
module im2col_address_generator #(
  parameter int INDEX_BITS = im2col_pkg::DEF_INDEX_BITS,
  parameter int DIM_BITS   = im2col_pkg::DEF_DIM_BITS,
  localparam int CFG_DATA_BITS = (DIM_BITS > im2col_pkg::CHAN_BITS)
                                 ? DIM_BITS : im2col_pkg::CHAN_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [im2col_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]              cfg_data,
  input  logic                                  step_valid,
  output logic                                  step_ready,
  input  logic                                  restart,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic                                  valid_res,
  output logic [INDEX_BITS-1:0]                 tensor_index,
  output logic [INDEX_BITS-1:0]                 column_index,
  output logic                                  patch_end,
  output logic                                  last,
  output logic                                  index_overflow
);
  import im2col_pkg::*;

  logic [BATCH_BITS-1:0] nb;
  logic [DIM_BITS-1:0]   hh, ww, oh, ow;
  logic [CHAN_BITS-1:0]  cc;
  logic [KSZ_BITS-1:0]   kh, kw, sh, sw;

  logic                  item_valid, item_ready;
  walk_flags_t           item_flags;
  logic [BATCH_BITS-1:0] item_batch;
  logic [DIM_BITS-1:0]   item_orow, item_ocol;
  logic [CHAN_BITS-1:0]  item_chan;
  logic [KSZ_BITS-1:0]   item_krow, item_kcol;

  im2col_cfg_regs #(
    .DIM_BITS      (DIM_BITS),
    .CFG_DATA_BITS (CFG_DATA_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .nb        (nb),
    .hh        (hh),
    .ww        (ww),
    .oh        (oh),
    .ow        (ow),
    .cc        (cc),
    .kh        (kh),
    .kw        (kw),
    .sh        (sh),
    .sw        (sw)
  );

  im2col_walk #(
    .DIM_BITS (DIM_BITS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .restart    (restart),
    .nb         (nb),
    .oh         (oh),
    .ow         (ow),
    .cc         (cc),
    .kh         (kh),
    .kw         (kw),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_flags (item_flags),
    .item_batch (item_batch),
    .item_orow  (item_orow),
    .item_ocol  (item_ocol),
    .item_chan  (item_chan),
    .item_krow  (item_krow),
    .item_kcol  (item_kcol)
  );

  im2col_index_pipe #(
    .INDEX_BITS (INDEX_BITS),
    .DIM_BITS   (DIM_BITS)
  ) u_pipe (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item_flags     (item_flags),
    .item_batch     (item_batch),
    .item_orow      (item_orow),
    .item_ocol      (item_ocol),
    .item_chan      (item_chan),
    .item_krow      (item_krow),
    .item_kcol      (item_kcol),
    .hh             (hh),
    .ww             (ww),
    .oh             (oh),
    .ow             (ow),
    .cc             (cc),
    .kh             (kh),
    .kw             (kw),
    .sh             (sh),
    .sw             (sw),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .valid_res      (valid_res),
    .tensor_index   (tensor_index),
    .column_index   (column_index),
    .patch_end      (patch_end),
    .last           (last),
    .index_overflow (index_overflow)
  );

endmodule

// ===== dv/im2col_address_generator_tb.sv =====
// ----------------------------------------------------------------------------
// im2col_address_generator_tb
// Self-checking bench for the im2col index pair generator. A behavioural
// walker keeps its own copy of the shape registers and loop positions, works
// out every index pair as each step is accepted, and the result monitor checks
// each returned item field by field, in order. Directed cases cover idle
// steps, zero sizes, index wrap, reshaping mid-pass and restarts. Random
// passes then run with random shapes under varying sender gaps and receiver
// back-pressure.
// ----------------------------------------------------------------------------
module im2col_address_generator_tb;
  import im2col_pkg::*;

  localparam int IDX_W = DEF_INDEX_BITS;
  localparam int DIM_W = DEF_DIM_BITS;
  localparam int CFG_W = (DIM_W > CHAN_BITS) ? DIM_W : CHAN_BITS;
  localparam longint unsigned IDX_MAX = (64'd1 << IDX_W) - 1;
  localparam int RANDOM_STEPS = 1600;

  typedef struct packed {
    logic             valid_res;
    logic [IDX_W-1:0] tensor_index;
    logic [IDX_W-1:0] column_index;
    logic             patch_end;
    logic             last;
    logic             index_overflow;
  } index_pair_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             step_valid = 1'b0;
  logic             step_ready;
  logic             restart = 1'b0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic             valid_res;
  logic [IDX_W-1:0] tensor_index;
  logic [IDX_W-1:0] column_index;
  logic             patch_end;
  logic             last;
  logic             index_overflow;

  // shadow copy of the shape registers
  logic [BATCH_BITS-1:0] sh_batch;
  logic [DIM_W-1:0]      sh_in_h, sh_in_w, sh_out_h, sh_out_w;
  logic [CHAN_BITS-1:0]  sh_chan;
  logic [SHAPE_BITS-1:0] sh_kernel, sh_stride;

  // loop positions of the walk
  longint unsigned at_batch, at_out_row, at_out_col, at_chan, at_krow, at_kcol;
  bit              walking;

  index_pair_t pending_pairs[$];
  index_pair_t want_pair;
  int          mismatches = 0;
  int          steps_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  im2col_address_generator i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .step_valid     (step_valid),
    .step_ready     (step_ready),
    .restart        (restart),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .valid_res      (valid_res),
    .tensor_index   (tensor_index),
    .column_index   (column_index),
    .patch_end      (patch_end),
    .last           (last),
    .index_overflow (index_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic longint unsigned at_least_one(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint unsigned pass_length();
    return at_least_one(64'(sh_batch)) * at_least_one(64'(sh_out_h))
           * at_least_one(64'(sh_out_w)) * at_least_one(64'(sh_chan))
           * at_least_one(64'(sh_kernel[3:0])) * at_least_one(64'(sh_kernel[7:4]));
  endfunction

  // work out the pair for one step and move the walk on
  function automatic void unfold_step(input logic rs);
    longint unsigned nb, hh, ww, oh, ow, cc, kh, kw, sr, sc;
    longint unsigned t_exact, c_exact, mat_row, mat_col;
    bit pend, fin;
    index_pair_t p;
    nb = at_least_one(64'(sh_batch));
    hh = at_least_one(64'(sh_in_h));
    ww = at_least_one(64'(sh_in_w));
    oh = at_least_one(64'(sh_out_h));
    ow = at_least_one(64'(sh_out_w));
    cc = at_least_one(64'(sh_chan));
    kh = at_least_one(64'(sh_kernel[3:0]));
    kw = at_least_one(64'(sh_kernel[7:4]));
    sr = at_least_one(64'(sh_stride[3:0]));
    sc = at_least_one(64'(sh_stride[7:4]));
    p = '0;
    if (rs) begin
      at_batch = 0; at_out_row = 0; at_out_col = 0;
      at_chan = 0; at_krow = 0; at_kcol = 0;
      walking = 1'b1;
    end
    if (walking) begin
      t_exact = (at_batch * cc * hh + sr * at_out_row) * ww + sc * at_out_col
                + at_chan * hh * ww + at_krow * ww + at_kcol;
      mat_row = (at_batch * oh + at_out_row) * ow + at_out_col;
      mat_col = (at_chan * kh + at_krow) * kw + at_kcol;
      c_exact = mat_row * (cc * kh * kw) + mat_col;
      pend = (at_kcol + 1 >= kw) && (at_krow + 1 >= kh) && (at_chan + 1 >= cc);
      fin = pend && (at_out_col + 1 >= ow) && (at_out_row + 1 >= oh)
            && (at_batch + 1 >= nb);
      p.valid_res      = 1'b1;
      p.tensor_index   = t_exact[IDX_W-1:0];
      p.column_index   = c_exact[IDX_W-1:0];
      p.patch_end      = pend;
      p.last           = fin;
      p.index_overflow = (t_exact > IDX_MAX) || (c_exact > IDX_MAX);
      // positions past a shrunk limit count as the end of their loop
      if (fin) begin
        walking = 1'b0;
        at_batch = 0; at_out_row = 0; at_out_col = 0;
        at_chan = 0; at_krow = 0; at_kcol = 0;
      end else if (at_kcol + 1 < kw) begin
        at_kcol++;
      end else begin
        at_kcol = 0;
        if (at_krow + 1 < kh) begin
          at_krow++;
        end else begin
          at_krow = 0;
          if (at_chan + 1 < cc) begin
            at_chan++;
          end else begin
            at_chan = 0;
            if (at_out_col + 1 < ow) begin
              at_out_col++;
            end else begin
              at_out_col = 0;
              if (at_out_row + 1 < oh) begin
                at_out_row++;
              end else begin
                at_out_row = 0;
                at_batch = (at_batch + 1 < nb) ? at_batch + 1 : 0;
              end
            end
          end
        end
      end
    end
    pending_pairs.push_back(p);
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected item, expected none, got tensor %0h column %0h",
                 $time, tensor_index, column_index);
        mismatches++;
      end else begin
        want_pair = pending_pairs.pop_front();
        check_field("valid_res", 64'(want_pair.valid_res), 64'(valid_res));
        check_field("tensor_index", 64'(want_pair.tensor_index), 64'(tensor_index));
        check_field("column_index", 64'(want_pair.column_index), 64'(column_index));
        check_field("patch_end", 64'(want_pair.patch_end), 64'(patch_end));
        check_field("last", 64'(want_pair.last), 64'(last));
        check_field("index_overflow", 64'(want_pair.index_overflow),
                    64'(index_overflow));
      end
    end
  end

  task automatic send_step(input logic rs);
    if ($urandom_range(99) < idle_pct) begin
      step_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    step_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk); while (!step_ready);
    unfold_step(rs);
    steps_sent++;
  endtask

  // drain the pipeline so the registers can be touched safely
  task automatic wait_idle();
    step_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BATCH_COUNT:  sh_batch  = val[BATCH_BITS-1:0];
      REG_IN_HEIGHT:    sh_in_h   = val[DIM_W-1:0];
      REG_IN_WIDTH:     sh_in_w   = val[DIM_W-1:0];
      REG_OUT_HEIGHT:   sh_out_h  = val[DIM_W-1:0];
      REG_OUT_WIDTH:    sh_out_w  = val[DIM_W-1:0];
      REG_CHANNELS:     sh_chan   = val[CHAN_BITS-1:0];
      REG_KERNEL_SHAPE: sh_kernel = val[SHAPE_BITS-1:0];
      REG_STRIDE_SHAPE: sh_stride = val[SHAPE_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 59; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 59; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // steps with no pass running, then a one-pair pass on the reset shape and one more idle step
  task automatic test_idle_steps();
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  // every size register at zero behaves as one
  task automatic test_zero_sizes();
    wait_idle();
    set_reg(REG_BATCH_COUNT, '0);
    set_reg(REG_IN_HEIGHT, '0);
    set_reg(REG_IN_WIDTH, '0);
    set_reg(REG_OUT_HEIGHT, '0);
    set_reg(REG_OUT_WIDTH, '0);
    set_reg(REG_CHANNELS, '0);
    set_reg(REG_KERNEL_SHAPE, '0);
    set_reg(REG_STRIDE_SHAPE, '0);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  // walk into the batch, grow every size but the batch count to its top so both indices wrap,
  // then shrink again so stale positions close their loops
  task automatic test_reshape_mid_pass();
    wait_idle();
    set_reg(REG_BATCH_COUNT, CFG_W'(3));
    send_step(1'b1);
    send_step(1'b0);
    wait_idle();
    set_reg(REG_IN_HEIGHT, '1);
    set_reg(REG_IN_WIDTH, '1);
    set_reg(REG_OUT_HEIGHT, '1);
    set_reg(REG_OUT_WIDTH, '1);
    set_reg(REG_CHANNELS, '1);
    set_reg(REG_KERNEL_SHAPE, CFG_W'(8'hff));
    set_reg(REG_STRIDE_SHAPE, CFG_W'(8'hff));
    send_step(1'b0);
    send_step(1'b0);
    wait_idle();
    set_reg(REG_KERNEL_SHAPE, CFG_W'(8'h11));
    set_reg(REG_CHANNELS, CFG_W'(1));
    set_reg(REG_OUT_HEIGHT, CFG_W'(1));
    set_reg(REG_OUT_WIDTH, CFG_W'(1));
    send_step(1'b0);
    send_step(1'b0);
  endtask

  task automatic test_random_passes();
    int pass_no;
    int cap;
    int k;
    longint unsigned len;
    bit narrow;
    pass_no = 0;
    while (steps_sent < RANDOM_STEPS + 20) begin
      wait_idle();
      set_idling(pass_no);
      narrow = ($urandom_range(99) < 75);
      set_reg(REG_BATCH_COUNT, CFG_W'(narrow ? $urandom_range(0, 2) : $urandom));
      set_reg(REG_IN_HEIGHT, CFG_W'($urandom));
      set_reg(REG_IN_WIDTH, CFG_W'($urandom));
      set_reg(REG_OUT_HEIGHT, CFG_W'(narrow ? $urandom_range(0, 2) : $urandom));
      set_reg(REG_OUT_WIDTH, CFG_W'(narrow ? $urandom_range(0, 2) : $urandom));
      set_reg(REG_CHANNELS, CFG_W'(narrow ? $urandom_range(0, 2) : $urandom));
      set_reg(REG_KERNEL_SHAPE,
              narrow ? CFG_W'({4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))})
                     : CFG_W'($urandom));
      set_reg(REG_STRIDE_SHAPE, CFG_W'($urandom));
      len = pass_length();
      cap = $urandom_range(12, 150);
      k = $urandom_range(99);
      if (k < 8) begin
        // noise: random mix of restarts and advances
        repeat ($urandom_range(5, 15)) send_step(1'($urandom_range(1)));
      end else if (len <= cap) begin
        // whole pass, sometimes carrying on from the previous walk
        send_step(k >= 20);
        for (k = 1; k < len; k++) send_step(1'b0);
        repeat ($urandom_range(0, 2)) send_step(1'b0);
      end else begin
        // cut short, with the odd restart part way
        send_step(1'b1);
        for (k = 1; k < cap; k++) send_step($urandom_range(99) < 3);
      end
      pass_no++;
    end
  endtask

  initial begin
    sh_batch = 1; sh_in_h = 1; sh_in_w = 1; sh_out_h = 1; sh_out_w = 1;
    sh_chan = 1; sh_kernel = RST_SHAPE; sh_stride = RST_SHAPE;
    at_batch = 0; at_out_row = 0; at_out_col = 0;
    at_chan = 0; at_krow = 0; at_kcol = 0;
    walking = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_steps();
    test_zero_sizes();
    test_reshape_mid_pass();
    test_random_passes();
    wait_idle();
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
